// File: design/vfre_pkg.sv
package vfre_pkg;

  localparam int ID_W        = 32;
  localparam int SID_W       = 8;
  localparam int VAL_W       = 64;
  localparam int GROUP_W     = 7;
  localparam int BYTE_W      = 8;
  localparam int IDLEN_W     = 3;
  localparam int VLEN_W      = 4;
  localparam int TDATA_W     = ID_W + SID_W + VAL_W;
  localparam int QUEUE_DEPTH = 2;

  localparam int ID_GROUPS  = (ID_W + GROUP_W - 1) / GROUP_W;
  localparam int VAL_GROUPS = (VAL_W + GROUP_W - 1) / GROUP_W;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [IDLEN_W-1:0] id_len;
    logic [VAL_W-1:0]   enc;
    logic [VLEN_W-1:0]  val_len;
  } vfre_entry_t;

endpackage

// File: design/vfre_front.sv
module vfre_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [vfre_pkg::TDATA_W-1:0] s_axis_tdata_i,
  input  logic                         s_axis_tuser_i,
  output logic                         ent_valid_o,
  input  logic                         ent_ready_i,
  output vfre_pkg::vfre_entry_t        ent_o
);
  import vfre_pkg::*;

  // The length is one more than the index of the highest group that holds a set bit.
  function automatic logic [IDLEN_W-1:0] id_groups(input logic [ID_W-1:0] v);
    logic [IDLEN_W-1:0] n;
    n = IDLEN_W'(1);
    for (int k = 1; k < ID_GROUPS; k++) begin
      if ((v >> (GROUP_W * k)) != '0) begin
        n = IDLEN_W'(k + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [VLEN_W-1:0] val_groups(input logic [VAL_W-1:0] v);
    logic [VLEN_W-1:0] n;
    n = VLEN_W'(1);
    for (int k = 1; k < VAL_GROUPS; k++) begin
      if ((v >> (GROUP_W * k)) != '0) begin
        n = VLEN_W'(k + 1);
      end
    end
    return n;
  endfunction

  logic [ID_W-1:0]  long_id;
  logic [SID_W-1:0] short_id;
  logic [VAL_W-1:0] value;
  vfre_entry_t      ent_d, ent_q;
  logic             vld_q;

  assign long_id  = s_axis_tdata_i[ID_W-1:0];
  assign short_id = s_axis_tdata_i[ID_W+SID_W-1:ID_W];
  assign value    = s_axis_tdata_i[TDATA_W-1:ID_W+SID_W];

  always_comb begin
    ent_d.id = (short_id != '0) ? {{(ID_W-SID_W){1'b0}}, short_id} : long_id;
    if (s_axis_tuser_i) begin
      ent_d.enc = {value[VAL_W-2:0], 1'b0} ^ {VAL_W{value[VAL_W-1]}};
    end else begin
      ent_d.enc = value;
    end
    ent_d.id_len  = id_groups(ent_d.id);
    ent_d.val_len = val_groups(ent_d.enc);
  end

  assign s_axis_tready_o = !vld_q || ent_ready_i;
  assign ent_valid_o     = vld_q;
  assign ent_o           = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      ent_q <= ent_d;
    end
  end

endmodule

// File: design/vfre_queue.sv
module vfre_queue #(
  parameter int Depth = vfre_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  vfre_pkg::vfre_entry_t push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output vfre_pkg::vfre_entry_t pop_data_o
);
  import vfre_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  vfre_entry_t   mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = cnt_q != CW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/vfre_back.sv
module vfre_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ent_valid_i,
  output logic                        ent_ready_o,
  input  vfre_pkg::vfre_entry_t       ent_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [vfre_pkg::BYTE_W-1:0] m_axis_tdata_o,
  output logic                        m_axis_tlast_o
);
  import vfre_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ID   = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;
  localparam logic [1:0] ST_VAL  = 2'd3;

  logic [1:0]        st_q, st_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [VAL_W-1:0]  enc_q, enc_d;
  logic [VLEN_W-1:0] vlen_q, vlen_d;
  logic [VLEN_W-1:0] cnt_q, cnt_d;
  logic              out_vld_q, out_vld_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              adv;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign ent_ready_o     = st_q == ST_IDLE;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    st_d       = st_q;
    id_d       = id_q;
    enc_d      = enc_q;
    vlen_d     = vlen_q;
    cnt_d      = cnt_q;
    out_vld_d  = adv ? 1'b0 : out_vld_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    case (st_q)
      ST_IDLE: begin
        if (ent_valid_i) begin
          id_d   = ent_i.id;
          enc_d  = ent_i.enc;
          vlen_d = ent_i.val_len;
          cnt_d  = VLEN_W'(ent_i.id_len);
          st_d   = ST_ID;
        end
      end
      ST_ID: begin
        if (adv) begin
          out_vld_d  = 1'b1;
          out_byte_d = {cnt_q != VLEN_W'(1), id_q[GROUP_W-1:0]};
          out_last_d = 1'b0;
          id_d       = id_q >> GROUP_W;
          cnt_d      = cnt_q - VLEN_W'(1);
          if (cnt_q == VLEN_W'(1)) begin
            st_d = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (adv) begin
          out_vld_d  = 1'b1;
          out_byte_d = {{(BYTE_W-VLEN_W){1'b0}}, vlen_q};
          out_last_d = 1'b0;
          cnt_d      = vlen_q;
          st_d       = ST_VAL;
        end
      end
      ST_VAL: begin
        if (adv) begin
          out_vld_d  = 1'b1;
          out_byte_d = {cnt_q != VLEN_W'(1), enc_q[GROUP_W-1:0]};
          out_last_d = cnt_q == VLEN_W'(1);
          enc_d      = enc_q >> GROUP_W;
          cnt_d      = cnt_q - VLEN_W'(1);
          if (cnt_q == VLEN_W'(1)) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    enc_q      <= enc_d;
    vlen_q     <= vlen_d;
    cnt_q      <= cnt_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

endmodule

// File: design/varint_field_record_encoder.sv
// Channel   Direction  Payload
// s_axis    in         tuser: command; tdata: long_id, short_id, value
// m_axis    out        tdata: out_byte; tlast: last
//
// A record of n bytes (n = id bytes + 1 + value bytes, from 3 to 16) occupies
// the byte serialiser: it loads the entry, then sends one byte a cycle unless m_axis stalls.
// The serialiser sets the rate; the input register and queue take new records meanwhile.
// Reset is asynchronous and active low and leaves all channels empty.
// A stall on m_axis holds the output byte and backs up into the queue and input.
module varint_field_record_encoder #(
  parameter int QueueDepth = vfre_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [31:0] long_id, [39:32] short_id, [103:40] value
  input  logic [vfre_pkg::TDATA_W-1:0] s_axis_tdata_i,
  // [0] command
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [7:0] out_byte
  output logic [vfre_pkg::BYTE_W-1:0]  m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);
  import vfre_pkg::*;

  vfre_entry_t front_ent, back_ent;
  logic        front_vld, front_rdy, back_vld, back_rdy;

  vfre_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .ent_valid_o     (front_vld),
    .ent_ready_i     (front_rdy),
    .ent_o           (front_ent)
  );

  vfre_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_vld),
    .push_ready_o (front_rdy),
    .push_data_i  (front_ent),
    .pop_valid_o  (back_vld),
    .pop_ready_i  (back_rdy),
    .pop_data_o   (back_ent)
  );

  vfre_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ent_valid_i     (back_vld),
    .ent_ready_o     (back_rdy),
    .ent_i           (back_ent),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import vfre_pkg::*;

  localparam logic        CMD_UNSIGNED = 1'b0;
  localparam logic        CMD_SIGNED   = 1'b1;
  localparam logic [63:0] GROUP_MASK   = 64'h7f;
  localparam logic [7:0]  MORE_FLAG    = 8'h80;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } record_byte_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [BYTE_W-1:0]   m_axis_tdata_o;
  logic                m_axis_tlast_o;

  record_byte_t expected_bytes[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  bit           in_gaps_on  = 1'b0;
  bit           out_stalls_on = 1'b0;
  int unsigned  hold_left   = 0;
  int unsigned  stall_left  = 0;

  varint_field_record_encoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  function automatic void push_varint(input logic [63:0] v);
    logic [63:0] rest;
    record_byte_t b;
    rest = v;
    while (rest > GROUP_MASK) begin
      b.data = rest[7:0] & GROUP_MASK[7:0] | MORE_FLAG;
      b.last = 1'b0;
      expected_bytes.push_back(b);
      rest = rest >> 7;
    end
    b.data = rest[7:0] & GROUP_MASK[7:0];
    b.last = 1'b0;
    expected_bytes.push_back(b);
  endfunction

  function automatic void encode_record(input logic cmd, input logic [31:0] lid,
                                        input logic [7:0] sid, input logic [63:0] val);
    logic [63:0]  id;
    logic [63:0]  enc;
    logic [63:0]  rest;
    int unsigned  vlen;
    record_byte_t b;
    id   = (sid != 8'd0) ? {56'd0, sid} : {32'd0, lid};
    enc  = (cmd == CMD_SIGNED) ? ((val << 1) ^ {64{val[63]}}) : val;
    vlen = 1;
    rest = enc;
    while (rest > GROUP_MASK) begin
      rest = rest >> 7;
      vlen++;
    end
    push_varint(id);
    push_varint(64'(vlen));
    push_varint(enc);
    b = expected_bytes.pop_back();
    b.last = 1'b1;
    expected_bytes.push_back(b);
  endfunction

  task automatic send_record(input logic cmd, input logic [31:0] lid,
                             input logic [7:0] sid, input logic [63:0] val);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {val, sid, lid};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    encode_record(cmd, lid, sid, val);
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_record();
    logic [63:0] val;
    logic [31:0] lid;
    logic [7:0]  sid;
    val = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      val = val >> $urandom_range(0, 63);
    end
    if ($urandom_range(0, 3) == 0) begin
      val = ~val;
    end
    lid = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      lid = lid >> $urandom_range(0, 31);
    end
    sid = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
    send_record(($urandom_range(0, 1) == 0) ? CMD_UNSIGNED : CMD_SIGNED, lid, sid, val);
  endtask

  task automatic wait_for_records();
    s_axis_tvalid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed_records();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    send_record(CMD_UNSIGNED, 32'h0000_0000, 8'h00, 64'h0);
    send_record(CMD_UNSIGNED, 32'hffff_ffff, 8'h00, 64'hffff_ffff_ffff_ffff);
    send_record(CMD_UNSIGNED, 32'h1234_5678, 8'hff, 64'h0);
    send_record(CMD_UNSIGNED, 32'h0000_0000, 8'h01, 64'h1);
    send_record(CMD_UNSIGNED, 32'hdead_beef, 8'h7f, 64'h7f);
    send_record(CMD_UNSIGNED, 32'h0000_0000, 8'h80, 64'h80);
    send_record(CMD_UNSIGNED, 32'h0000_007f, 8'h00, 64'h3fff);
    send_record(CMD_UNSIGNED, 32'h0000_0080, 8'h00, 64'h4000);
    send_record(CMD_UNSIGNED, 32'h0000_3fff, 8'h00, 64'h8000_0000_0000_0000);
    send_record(CMD_UNSIGNED, 32'h0000_4000, 8'h00, 64'h7fff_ffff_ffff_ffff);
    send_record(CMD_SIGNED,   32'h0000_0000, 8'h00, 64'h0);
    send_record(CMD_SIGNED,   32'h0000_0001, 8'h00, 64'hffff_ffff_ffff_ffff);
    send_record(CMD_SIGNED,   32'h8000_0000, 8'h00, 64'h1);
    send_record(CMD_SIGNED,   32'h0000_0000, 8'h2a, 64'h8000_0000_0000_0000);
    send_record(CMD_SIGNED,   32'h0000_0000, 8'h2b, 64'h7fff_ffff_ffff_ffff);
    send_record(CMD_SIGNED,   32'h0000_0000, 8'h03, 64'hffff_ffff_ffff_fffb);
    send_record(CMD_SIGNED,   32'h0000_0000, 8'h04, 64'hffff_ffff_ffff_ffc0);
    send_record(CMD_SIGNED,   32'h0000_0000, 8'h05, 64'h40);
    send_record(CMD_SIGNED,   32'h0000_0000, 8'h06, 64'h3f);
    wait_for_records();
  endtask

  task automatic test_random_records();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    repeat (100) send_random_record();
    wait_for_records();
  endtask

  task automatic test_back_to_back();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    repeat (30) send_random_record();
    wait_for_records();
  endtask

  task automatic test_output_hold_off();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b1;
    hold_left     = 300;
    repeat (12) send_random_record();
    wait_for_records();
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (out_stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    record_byte_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, got %02h last %0b",
                 $time, m_axis_tdata_o, m_axis_tlast_o);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata_o !== want.data || m_axis_tlast_o !== want.last) begin
          $display("%0t: byte mismatch, expected %02h last %0b, got %02h last %0b",
                   $time, want.data, want.last, m_axis_tdata_o, m_axis_tlast_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("varint_field_record_encoder test failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_records();
    test_random_records();
    test_output_hold_off();
    test_back_to_back();
    if (error_count == 0) begin
      $display("varint_field_record_encoder test passed");
    end else begin
      $display("varint_field_record_encoder test failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/vfre_pkg.sv
design/vfre_front.sv
design/vfre_queue.sv
design/vfre_back.sv
design/varint_field_record_encoder.sv
tb/sv/tb.sv
